>>> hdl/spq_pkg.sv
// Shared constants and types for the sorted priority queue.
package spq_pkg;

    localparam int QueueDepth = 16;
    localparam int ValueWidth = 32;
    localparam int FillWidth  = 5;
    localparam int StatusWidth = 2;

    localparam logic [StatusWidth-1:0] STATUS_OK    = 2'd0;
    localparam logic [StatusWidth-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [StatusWidth-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic push;
        logic pop;
        logic occ;
    } t_cell_ctl;

endpackage

>>> hdl/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts toward either neighbor.
module spq_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  spq_pkg::t_cell_ctl     i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [VALUE_WIDTH-1:0] i_prev_data,
    input  logic                   i_prev_ge,
    input  logic [VALUE_WIDTH-1:0] i_next_data,
    output logic [VALUE_WIDTH-1:0] o_data,
    output logic                   o_ge
);
    import spq_pkg::*;

    logic [VALUE_WIDTH-1:0] r_data;
    logic [VALUE_WIDTH-1:0] n_data;

    assign o_ge   = i_ctl.occ && ($signed(r_data) >= $signed(i_value));
    assign o_data = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.push && !o_ge) begin
            n_data = i_prev_ge ? i_value : i_prev_data;
        end else if (i_ctl.pop) begin
            n_data = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

>>> hdl/sorted_priority_queue_top.sv
// Bounded max-priority queue built from a chain of sorting cells.
//
// Input channel: i_in_valid / o_in_stall carry one request per beat:
// i_req_type 0 inserts i_value, 1 removes the largest stored value.
// Output channel: o_out_valid / i_out_stall carry one result per request:
// o_status (ok, removal from empty, insert when full), o_removed_value
// (the removed value on a successful removal, else zero) and o_fill_count
// (entries stored after the request).
// All cells compare the new value against their entry in parallel and
// shift in the same clock edge; the result is registered and shows on the
// output in the cycle after acceptance. A new request is taken every cycle
// while the output register is empty or is being drained, so sustained
// throughput is one beat per cycle.
// Reset clears the entry count and the output valid flag; cell contents are
// not cleared, since only occupied cells are ever compared or read.
// While the receiver stalls, the result holds and o_in_stall rises once the
// output register is full.
module sorted_priority_queue_top #(
    parameter int QUEUE_DEPTH = spq_pkg::QueueDepth,
    parameter int VALUE_WIDTH = spq_pkg::ValueWidth
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic signed [31:0]                i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [spq_pkg::StatusWidth-1:0]   o_status,
    output logic signed [31:0]                o_removed_value,
    output logic [spq_pkg::FillWidth-1:0]     o_fill_count
);
    import spq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_out_valid;
    logic [StatusWidth-1:0] r_status;
    logic [StatusWidth-1:0] n_status;
    logic [31:0]            r_removed;
    logic [31:0]            n_removed;
    logic [CW-1:0]          r_fill;

    logic                   accept;
    logic                   full;
    logic                   empty;
    logic                   push;
    logic                   pop;
    logic [VALUE_WIDTH-1:0] value;

    logic [VALUE_WIDTH-1:0] data [QUEUE_DEPTH];
    logic                   ge   [QUEUE_DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = (r_count == CW'(QUEUE_DEPTH));
    assign empty      = (r_count == '0);
    assign push       = accept && !i_req_type && !full;
    assign pop        = accept && i_req_type && !empty;
    assign value      = VALUE_WIDTH'($unsigned(i_value));

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_cell_ctl              ctl;
        logic [VALUE_WIDTH-1:0] prev_data;
        logic                   prev_ge;
        logic [VALUE_WIDTH-1:0] next_data;

        assign ctl.push = push;
        assign ctl.pop  = pop;
        assign ctl.occ  = (CW'(g) < r_count);

        if (g == 0) begin : g_first
            assign prev_data = value;
            assign prev_ge   = 1'b1;
        end else begin : g_mid
            assign prev_data = data[g-1];
            assign prev_ge   = ge[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign next_data = '0;
        end else begin : g_inner
            assign next_data = data[g+1];
        end

        spq_cell #(
            .VALUE_WIDTH(VALUE_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_value    (value),
            .i_prev_data(prev_data),
            .i_prev_ge  (prev_ge),
            .i_next_data(next_data),
            .o_data     (data[g]),
            .o_ge       (ge[g])
        );
    end

    always_comb begin
        n_count   = r_count;
        n_status  = STATUS_OK;
        n_removed = '0;
        if (push) begin
            n_count = r_count + CW'(1);
        end else if (pop) begin
            n_count   = r_count - CW'(1);
            n_removed = 32'(data[0]);
        end
        if (accept && !i_req_type && full) begin
            n_status = STATUS_FULL;
        end else if (accept && i_req_type && empty) begin
            n_status = STATUS_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_removed <= n_removed;
            r_fill    <= n_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_removed_value = $signed(r_removed);
    assign o_fill_count    = FillWidth'(r_fill);

endmodule

>>> hdl/spq_chk.sv
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_chk #(
    parameter int QUEUE_DEPTH = spq_pkg::QueueDepth
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [spq_pkg::StatusWidth-1:0] o_status,
    input logic signed [31:0]              o_removed_value,
    input logic [spq_pkg::FillWidth-1:0]   o_fill_count
);
    import spq_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status))
        else $error("stalled result beat dropped or changed");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == STATUS_EMPTY |->
            o_removed_value == 0 && o_fill_count == '0)
        else $error("empty removal with nonzero value or count");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == STATUS_FULL |->
            o_removed_value == 0 && o_fill_count == FillWidth'(QUEUE_DEPTH))
        else $error("full insert with wrong value or count");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat present after reset");

    a_beat_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted request gave no result beat");

endmodule

bind sorted_priority_queue_top spq_chk #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_spq_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_removed_value(o_removed_value),
    .o_fill_count   (o_fill_count)
);

>>> test/tb_top.sv
// Self-checking testbench for the sorted max-priority queue: directed and random beats.
`timescale 1ns / 100ps

module tb_top;

    import spq_pkg::*;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   RANDOM_ITEMS = 1500;
    localparam logic signed [ValueWidth-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ValueWidth-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [StatusWidth-1:0]       status;
        logic signed [ValueWidth-1:0] removed;
        logic [FillWidth-1:0]         fill;
    } t_queue_result;

    class order_checker;
        logic signed [ValueWidth-1:0] stored_values[$];
        t_queue_result                pending_results[$];
        int                           errors = 0;

        function void note_request(logic req, logic signed [ValueWidth-1:0] val);
            t_queue_result res;
            int            pos;
            res.status  = STATUS_OK;
            res.removed = '0;
            if (req == REQ_INSERT) begin
                if (stored_values.size() >= QueueDepth) begin
                    res.status = STATUS_FULL;
                end else begin
                    pos = 0;
                    while (pos < stored_values.size() && stored_values[pos] >= val) pos++;
                    stored_values.insert(pos, val);
                end
            end else begin
                if (stored_values.size() == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    res.removed = stored_values.pop_front();
                end
            end
            res.fill = FillWidth'(stored_values.size());
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [StatusWidth-1:0] status,
                                   logic signed [ValueWidth-1:0] removed,
                                   logic [FillWidth-1:0] fill);
            t_queue_result exp_res;
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: status %0d value %0d fill %0d",
                       status, removed, fill);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (status !== exp_res.status) begin
                $error("status: expected %0d, got %0d", exp_res.status, status);
                errors++;
            end
            if (removed !== exp_res.removed) begin
                $error("removed_value: expected %0d, got %0d", exp_res.removed, removed);
                errors++;
            end
            if (fill !== exp_res.fill) begin
                $error("fill_count: expected %0d, got %0d", exp_res.fill, fill);
                errors++;
            end
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic                         i_req_type;
    logic signed [ValueWidth-1:0] i_value;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic [StatusWidth-1:0]       o_status;
    logic signed [ValueWidth-1:0] o_removed_value;
    logic [FillWidth-1:0]         o_fill_count;

    order_checker sb;
    int send_idle_pct = 23;
    int recv_stall_pct = 45;
    int cycle_count = 0;

    sorted_priority_queue_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_fill_count    (o_fill_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // outputs only move at the rising edge, so the falling edge sees what the next edge takes
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_status, o_removed_value, o_fill_count);
        end
    end

    task automatic send_item(input logic req, input logic signed [ValueWidth-1:0] val);
        logic stalled;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_value    <= val;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            if (!stalled) sb.note_request(req, val);
            @(posedge i_clk);
        end while (stalled);
    endtask

    function automatic logic signed [ValueWidth-1:0] pick_value();
        case ($urandom_range(0, 4))
            0, 1: return $urandom;
            2: return $signed($urandom_range(0, 8)) - 4;
            3: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: begin
                if ($urandom_range(0, 1)) return VAL_MAX - $urandom_range(0, 3);
                return VAL_MIN + $urandom_range(0, 3);
            end
        endcase
    endfunction

    initial begin
        int insert_pct;
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_req_type  <= REQ_INSERT;
        i_value     <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(REQ_REMOVE, $urandom);
        send_item(REQ_INSERT, VAL_MAX);
        send_item(REQ_INSERT, VAL_MIN);
        send_item(REQ_INSERT, 0);
        send_item(REQ_INSERT, -1);
        send_item(REQ_INSERT, 1);
        send_item(REQ_INSERT, 0);
        send_item(REQ_REMOVE, $urandom);
        for (int i = 0; i < 11; i++) begin
            send_item(REQ_INSERT, (i % 3 == 0) ? 0 : pick_value());
        end
        send_item(REQ_INSERT, VAL_MAX);
        send_item(REQ_INSERT, VAL_MIN);
        send_item(REQ_REMOVE, $urandom);

        insert_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct  = 45;
                recv_stall_pct = 23;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            // drift between filling and draining so both full and empty recur
            if (n % 40 == 0) begin
                case ($urandom_range(0, 3))
                    0: insert_pct = 20;
                    1: insert_pct = 50;
                    2: insert_pct = 80;
                    default: insert_pct = 95;
                endcase
            end
            if ($urandom_range(0, 99) < insert_pct) send_item(REQ_INSERT, pick_value());
            else send_item(REQ_REMOVE, $urandom);
        end
        i_in_valid <= 1'b0;

        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
